### rtl/rchit_pkg.sv
// Shared constants and types for the ray against finite cylinder hit test.
// Used by rchit_mul and ray_cylinder_hit_test; depends on nothing else.
`timescale 1ns / 1ps

package rchit_pkg;

  // Default coordinate width (signed Q12.12).
  localparam int COORD_WIDTH_DEF = 24;

  // Limb width of the split multiplier and its fixed latency in cycles.
  // The adder tree gets MUL_LAT-3 levels, enough for 128 limb products.
  localparam int LIMB_W  = 32;
  localparam int MUL_LAT = 10;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_START_X,
    REG_AXIS_START_Y,
    REG_AXIS_START_Z,
    REG_AXIS_END_X,
    REG_AXIS_END_Y,
    REG_AXIS_END_Z,
    REG_RADIUS
  } cfg_reg_t;

  // Decision flags that travel alongside the wide arithmetic.
  typedef struct packed {
    logic ok;       // all sign tests so far pass
    logic f_neg;    // axial component of the direction is negative
    logic f_zero;   // axial component of the direction is zero
    logic k_neg;    // first root bound term is negative
    logic lim_neg;  // second root bound term is negative
  } cond_t;

endpackage

### rtl/rchit_mul.sv
// Pipelined exact signed multiplier built from limb products and a
// registered adder tree; uses rchit_pkg.
`timescale 1ns / 1ps

module rchit_mul #(
  parameter int AW = 25,
  parameter int BW = 25
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  import rchit_pkg::*;

  localparam int PW = AW + BW;
  localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
  localparam int NB = (BW + LIMB_W - 1) / LIMB_W;
  localparam int NP = NA * NB;
  localparam int TL = MUL_LAT - 3;

  logic [AW-1:0] am;
  logic [BW-1:0] bm;
  logic          neg0;
  logic [NA*LIMB_W-1:0] ax;
  logic [NB*LIMB_W-1:0] bx;
  logic [PW-1:0] tr [TL+1][NP];
  logic [TL:0]   sg;

  // Magnitudes first, so that every limb product is unsigned.
  always_ff @(posedge clk) begin
    if (en) begin
      am   <= a[AW-1] ? AW'(-a) : AW'(a);
      bm   <= b[BW-1] ? BW'(-b) : BW'(b);
      neg0 <= a[AW-1] ^ b[BW-1];
    end
  end

  assign ax = (NA*LIMB_W)'(am);
  assign bx = (NB*LIMB_W)'(bm);

  for (genvar ia = 0; ia < NA; ia++) begin : g_la
    for (genvar jb = 0; jb < NB; jb++) begin : g_lb
      localparam int SH = LIMB_W * (ia + jb);
      logic [2*LIMB_W-1:0] pr;
      assign pr = ax[ia*LIMB_W +: LIMB_W] * bx[jb*LIMB_W +: LIMB_W];
      always_ff @(posedge clk) begin
        if (en) begin
          tr[0][ia*NB+jb] <= PW'(pr) << SH;
        end
      end
    end
  end

  for (genvar l = 0; l < TL; l++) begin : g_lvl
    for (genvar i = 0; i < NP; i++) begin : g_node
      if (2*i+1 < NP) begin : g_pair
        always_ff @(posedge clk) begin
          if (en) begin
            tr[l+1][i] <= tr[l][2*i] + tr[l][2*i+1];
          end
        end
      end else if (2*i < NP) begin : g_single
        always_ff @(posedge clk) begin
          if (en) begin
            tr[l+1][i] <= tr[l][2*i];
          end
        end
      end else begin : g_none
        always_ff @(posedge clk) begin
          if (en) begin
            tr[l+1][i] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg <= {sg[TL-1:0], neg0};
      p  <= sg[TL] ? $signed(-tr[TL][0]) : $signed(tr[TL][0]);
    end
  end

endmodule

### rtl/ray_cylinder_hit_test.sv
// Each accepted item passes the difference register, four chained multiplier
// groups with registers between them, and the result register.
// Throughput: one item per cycle while the output side keeps taking results.
// Reset clears the configuration registers and the pipeline valid bits.
// Depends on rchit_pkg and rchit_mul.
`timescale 1ns / 1ps

module ray_cylinder_hit_test #(
  parameter int COORD_WIDTH = rchit_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  // configuration write port
  input  logic                           cfg_wen,
  input  logic [rchit_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [COORD_WIDTH-1:0]          cfg_wdata,
  // ray input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] ray_start_x,
  input  logic signed [COORD_WIDTH-1:0] ray_start_y,
  input  logic signed [COORD_WIDTH-1:0] ray_start_z,
  input  logic signed [COORD_WIDTH-1:0] ray_end_x,
  input  logic signed [COORD_WIDTH-1:0] ray_end_y,
  input  logic signed [COORD_WIDTH-1:0] ray_end_z,
  // result channel
  output logic out_valid,
  input  logic out_ready,
  output logic hit
);
  import rchit_pkg::*;

  // The test is done exactly on integers. With D = E - S, AB = B - A,
  // AO = S - A, U = D x AB and W = AO x AB we form a = U.U, h = U.W and
  // c = W.W - R*R*(AB.AB). A hit needs AB.AB > 0, a > 0, h <= 0, c >= 0 and a
  // non-negative discriminant h*h - a*c. The axial parameter of the nearer
  // root lies in [0,1] when K - f*sqrt(dd) >= 0 and
  // (AB.AB)*a - K + f*sqrt(dd) >= 0, with e = AO.AB, f = D.AB and
  // K = e*a - f*h. Both are settled by sign analysis and by squaring, so no
  // square root is ever taken. Every width below holds its value exactly.
  localparam int DW  = COORD_WIDTH + 1;         // coordinate differences
  localparam int PW1 = 2 * DW;                  // products of differences
  localparam int CW  = PW1 + 1;                 // cross product components
  localparam int EW  = PW1 + 2;                 // AB.AB, e and f
  localparam int R2W = 2 * COORD_WIDTH;         // radius squared
  localparam int Q2W = 2 * CW;                  // products of cross terms
  localparam int HW  = 2 * CW + 3;              // a, h and c
  localparam int DDW = 2 * HW + 1;              // discriminant
  localparam int KW  = EW + HW + 1;             // K
  localparam int LW  = KW + 1;                  // upper bound term
  localparam int FFW = 2 * EW;                  // f squared
  localparam int XW  = 2 * LW + 1;              // squared comparisons
  localparam int LAT = 4 * MUL_LAT + 8;

  // Configuration registers.
  logic signed [COORD_WIDTH-1:0] axa [3];
  logic signed [COORD_WIDTH-1:0] axb [3];
  logic [COORD_WIDTH-2:0]        rad;

  // Input fields as vectors.
  logic signed [COORD_WIDTH-1:0] rs   [3];
  logic signed [COORD_WIDTH-1:0] rend [3];

  // Pipeline control. The whole pipeline moves together; it only halts when
  // the result register holds an item that the far side has not taken.
  logic           adv;
  logic [LAT-1:0] vld;

  // First register stage: differences.
  logic signed [DW-1:0]   ao0 [3];
  logic signed [DW-1:0]   dv0 [3];
  logic signed [DW-1:0]   ab0 [3];
  logic [COORD_WIDTH-2:0] rr0;
  logic signed [COORD_WIDTH-1:0] rr0s;

  // First multiplier group.
  logic signed [PW1-1:0] wp [3];
  logic signed [PW1-1:0] wq [3];
  logic signed [PW1-1:0] up [3];
  logic signed [PW1-1:0] uq [3];
  logic signed [PW1-1:0] abp [3];
  logic signed [PW1-1:0] ep [3];
  logic signed [PW1-1:0] fp [3];
  logic signed [R2W-1:0] rrp;

  // Cross products, dot products of the axis.
  logic signed [CW-1:0]  wv1 [3];
  logic signed [CW-1:0]  uv1 [3];
  logic signed [EW-1:0]  ab2_1;
  logic signed [EW-1:0]  e1;
  logic signed [EW-1:0]  f1;
  logic signed [R2W-1:0] rr2_1;

  // Second multiplier group and its side delay lines.
  logic signed [Q2W-1:0]     uu [3];
  logic signed [Q2W-1:0]     uw [3];
  logic signed [Q2W-1:0]     ww [3];
  logic signed [R2W+EW-1:0]  rt;
  logic signed [EW-1:0]      ab2_dl [MUL_LAT];
  logic signed [EW-1:0]      e_dl   [MUL_LAT];
  logic signed [EW-1:0]      f_dl   [MUL_LAT];

  // Quadratic coefficients.
  logic signed [HW-1:0]      a2;
  logic signed [HW-1:0]      h2;
  logic signed [HW-1:0]      c0_2;
  logic signed [R2W+EW-1:0]  t2;
  logic signed [EW-1:0]      ab2_2;
  logic signed [EW-1:0]      e2;
  logic signed [EW-1:0]      f2;
  logic signed [HW-1:0]      a3;
  logic signed [HW-1:0]      h3;
  logic signed [HW-1:0]      c3;
  logic signed [EW-1:0]      ab2_3;
  logic signed [EW-1:0]      e3;
  logic signed [EW-1:0]      f3;
  cond_t                     fl3;

  // Third multiplier group.
  logic signed [2*HW-1:0]   hh;
  logic signed [2*HW-1:0]   ac;
  logic signed [EW+HW-1:0]  ea;
  logic signed [EW+HW-1:0]  fh;
  logic signed [EW+HW-1:0]  ba;
  logic signed [FFW-1:0]    ff;
  cond_t                    fl3_dl [MUL_LAT];

  // Discriminant and root bound terms.
  logic signed [DDW-1:0]    dd4;
  logic signed [KW-1:0]     k4;
  logic signed [EW+HW-1:0]  ba4;
  logic signed [FFW-1:0]    ff4;
  cond_t                    fl4;
  logic signed [LW-1:0]     lim_next;
  logic signed [LW-1:0]     lim5;
  logic signed [KW-1:0]     k5;
  logic signed [DDW-1:0]    dd5;
  logic signed [FFW-1:0]    ff5;
  cond_t                    fl5;

  // Fourth multiplier group.
  logic signed [2*KW-1:0]     kk;
  logic signed [2*LW-1:0]     ll;
  logic signed [FFW+DDW-1:0]  fd;
  cond_t                      fl5_dl [MUL_LAT];

  // Squared comparisons and the final decision.
  logic signed [XW-1:0] x1;
  logic signed [XW-1:0] x2;
  cond_t                fl6;
  logic                 r1;
  logic                 r2;

  assign rs[0]   = ray_start_x;
  assign rs[1]   = ray_start_y;
  assign rs[2]   = ray_start_z;
  assign rend[0] = ray_end_x;
  assign rend[1] = ray_end_y;
  assign rend[2] = ray_end_z;

  // Configuration writes. Indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < 3; n++) begin
        axa[n] <= '0;
        axb[n] <= '0;
      end
      rad <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_AXIS_START_X: axa[0] <= cfg_wdata;
        REG_AXIS_START_Y: axa[1] <= cfg_wdata;
        REG_AXIS_START_Z: axa[2] <= cfg_wdata;
        REG_AXIS_END_X:   axb[0] <= cfg_wdata;
        REG_AXIS_END_Y:   axb[1] <= cfg_wdata;
        REG_AXIS_END_Z:   axb[2] <= cfg_wdata;
        REG_RADIUS:       rad    <= cfg_wdata[COORD_WIDTH-2:0];
        default: ;
      endcase
    end
  end

  // The result register parts the two sides: a new item is taken whenever
  // the result register is empty or its item is being taken this cycle.
  assign adv       = !vld[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Stage one: differences of the points.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < 3; n++) begin
        ao0[n] <= DW'(rs[n]) - DW'(axa[n]);
        dv0[n] <= DW'(rend[n]) - DW'(rs[n]);
        ab0[n] <= DW'(axb[n]) - DW'(axa[n]);
      end
      rr0 <= rad;
    end
  end

  assign rr0s = $signed({1'b0, rr0});

  // First multiplier group: cross product terms, axis dot products and the
  // radius squared.
  for (genvar g = 0; g < 3; g++) begin : g_m1
    localparam int J = (g + 1) % 3;
    localparam int K = (g + 2) % 3;
    rchit_mul #(.AW(DW), .BW(DW)) u_wp (
      .clk(clk), .en(adv), .a(ao0[J]), .b(ab0[K]), .p(wp[g]));
    rchit_mul #(.AW(DW), .BW(DW)) u_wq (
      .clk(clk), .en(adv), .a(ao0[K]), .b(ab0[J]), .p(wq[g]));
    rchit_mul #(.AW(DW), .BW(DW)) u_up (
      .clk(clk), .en(adv), .a(dv0[J]), .b(ab0[K]), .p(up[g]));
    rchit_mul #(.AW(DW), .BW(DW)) u_uq (
      .clk(clk), .en(adv), .a(dv0[K]), .b(ab0[J]), .p(uq[g]));
    rchit_mul #(.AW(DW), .BW(DW)) u_abp (
      .clk(clk), .en(adv), .a(ab0[g]), .b(ab0[g]), .p(abp[g]));
    rchit_mul #(.AW(DW), .BW(DW)) u_ep (
      .clk(clk), .en(adv), .a(ao0[g]), .b(ab0[g]), .p(ep[g]));
    rchit_mul #(.AW(DW), .BW(DW)) u_fp (
      .clk(clk), .en(adv), .a(dv0[g]), .b(ab0[g]), .p(fp[g]));
  end

  rchit_mul #(.AW(COORD_WIDTH), .BW(COORD_WIDTH)) u_rr (
    .clk(clk), .en(adv), .a(rr0s), .b(rr0s), .p(rrp));

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < 3; n++) begin
        wv1[n] <= CW'(wp[n]) - CW'(wq[n]);
        uv1[n] <= CW'(up[n]) - CW'(uq[n]);
      end
      ab2_1 <= EW'(abp[0]) + EW'(abp[1]) + EW'(abp[2]);
      e1    <= EW'(ep[0]) + EW'(ep[1]) + EW'(ep[2]);
      f1    <= EW'(fp[0]) + EW'(fp[1]) + EW'(fp[2]);
      rr2_1 <= rrp;
    end
  end

  // Second multiplier group: a, h and W.W terms, and R*R*(AB.AB).
  for (genvar g = 0; g < 3; g++) begin : g_m2
    rchit_mul #(.AW(CW), .BW(CW)) u_uu (
      .clk(clk), .en(adv), .a(uv1[g]), .b(uv1[g]), .p(uu[g]));
    rchit_mul #(.AW(CW), .BW(CW)) u_uw (
      .clk(clk), .en(adv), .a(uv1[g]), .b(wv1[g]), .p(uw[g]));
    rchit_mul #(.AW(CW), .BW(CW)) u_ww (
      .clk(clk), .en(adv), .a(wv1[g]), .b(wv1[g]), .p(ww[g]));
  end

  rchit_mul #(.AW(R2W), .BW(EW)) u_rt (
    .clk(clk), .en(adv), .a(rr2_1), .b(ab2_1), .p(rt));

  // The axis terms wait for the multipliers alongside them.
  always_ff @(posedge clk) begin
    if (adv) begin
      ab2_dl[0] <= ab2_1;
      e_dl[0]   <= e1;
      f_dl[0]   <= f1;
      for (int n = 1; n < MUL_LAT; n++) begin
        ab2_dl[n] <= ab2_dl[n-1];
        e_dl[n]   <= e_dl[n-1];
        f_dl[n]   <= f_dl[n-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2    <= HW'(uu[0]) + HW'(uu[1]) + HW'(uu[2]);
      h2    <= HW'(uw[0]) + HW'(uw[1]) + HW'(uw[2]);
      c0_2  <= HW'(ww[0]) + HW'(ww[1]) + HW'(ww[2]);
      t2    <= rt;
      ab2_2 <= ab2_dl[MUL_LAT-1];
      e2    <= e_dl[MUL_LAT-1];
      f2    <= f_dl[MUL_LAT-1];
      a3    <= a2;
      h3    <= h2;
      c3    <= c0_2 - HW'(t2);
      ab2_3 <= ab2_2;
      e3    <= e2;
      f3    <= f2;
    end
  end

  // Sign tests that need only the coefficients.
  always_comb begin
    fl3.ok = (!ab2_3[EW-1] && (|ab2_3)) && (!a3[HW-1] && (|a3)) &&
             (h3[HW-1] || !(|h3)) && !c3[HW-1];
    fl3.f_neg   = f3[EW-1];
    fl3.f_zero  = !(|f3);
    fl3.k_neg   = 1'b0;
    fl3.lim_neg = 1'b0;
  end

  // Third multiplier group.
  rchit_mul #(.AW(HW), .BW(HW)) u_hh (
    .clk(clk), .en(adv), .a(h3), .b(h3), .p(hh));
  rchit_mul #(.AW(HW), .BW(HW)) u_ac (
    .clk(clk), .en(adv), .a(a3), .b(c3), .p(ac));
  rchit_mul #(.AW(EW), .BW(HW)) u_ea (
    .clk(clk), .en(adv), .a(e3), .b(a3), .p(ea));
  rchit_mul #(.AW(EW), .BW(HW)) u_fh (
    .clk(clk), .en(adv), .a(f3), .b(h3), .p(fh));
  rchit_mul #(.AW(EW), .BW(HW)) u_ba (
    .clk(clk), .en(adv), .a(ab2_3), .b(a3), .p(ba));
  rchit_mul #(.AW(EW), .BW(EW)) u_ff (
    .clk(clk), .en(adv), .a(f3), .b(f3), .p(ff));

  always_ff @(posedge clk) begin
    if (adv) begin
      fl3_dl[0] <= fl3;
      fl5_dl[0] <= fl5;
      for (int n = 1; n < MUL_LAT; n++) begin
        fl3_dl[n] <= fl3_dl[n-1];
        fl5_dl[n] <= fl5_dl[n-1];
      end
    end
  end

  assign lim_next = LW'(ba4) - LW'(k4);

  always_ff @(posedge clk) begin
    if (adv) begin
      dd4         <= DDW'(hh) - DDW'(ac);
      k4          <= KW'(ea) - KW'(fh);
      ba4         <= ba;
      ff4         <= ff;
      fl4         <= fl3_dl[MUL_LAT-1];
      lim5        <= lim_next;
      k5          <= k4;
      dd5         <= dd4;
      ff5         <= ff4;
      fl5.ok      <= fl4.ok && !dd4[DDW-1];
      fl5.f_neg   <= fl4.f_neg;
      fl5.f_zero  <= fl4.f_zero;
      fl5.k_neg   <= k4[KW-1];
      fl5.lim_neg <= lim_next[LW-1];
    end
  end

  // Fourth multiplier group: squares for the root bound comparisons.
  rchit_mul #(.AW(KW), .BW(KW)) u_kk (
    .clk(clk), .en(adv), .a(k5), .b(k5), .p(kk));
  rchit_mul #(.AW(LW), .BW(LW)) u_ll (
    .clk(clk), .en(adv), .a(lim5), .b(lim5), .p(ll));
  rchit_mul #(.AW(FFW), .BW(DDW)) u_fd (
    .clk(clk), .en(adv), .a(ff5), .b(dd5), .p(fd));

  always_ff @(posedge clk) begin
    if (adv) begin
      x1  <= XW'(kk) - XW'(fd);
      x2  <= XW'(ll) - XW'(fd);
      fl6 <= fl5_dl[MUL_LAT-1];
    end
  end

  // Each bound has the form p + q*sqrt(dd) >= 0. Where p and q agree in sign
  // the answer is plain; otherwise p*p - q*q*dd decides it.
  always_comb begin
    // Lower bound: p = K, q = -f.
    priority if (!fl6.k_neg && (fl6.f_neg || fl6.f_zero)) begin
      r1 = 1'b1;
    end else if (fl6.k_neg && !fl6.f_neg) begin
      r1 = 1'b0;
    end else if (!fl6.k_neg) begin
      r1 = !x1[XW-1];
    end else begin
      r1 = x1[XW-1] || !(|x1);
    end
    // Upper bound: p = (AB.AB)*a - K, q = f.
    priority if (!fl6.lim_neg && !fl6.f_neg) begin
      r2 = 1'b1;
    end else if (fl6.lim_neg && (fl6.f_neg || fl6.f_zero)) begin
      r2 = 1'b0;
    end else if (!fl6.lim_neg) begin
      r2 = !x2[XW-1];
    end else begin
      r2 = x2[XW-1] || !(|x2);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= fl6.ok && r1 && r2;
    end
  end

`ifndef SYNTHESIS
  // A halted pipeline keeps its items and its result.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld) && $stable(hit))
    else $error("pipeline moved while halted");

  // A degenerate axis can never report a hit.
  a_degenerate_axis: assert property (@(posedge clk) disable iff (rst)
    out_valid && axa[0] == axb[0] && axa[1] == axb[1] && axa[2] == axb[2]
    |-> !hit)
    else $error("hit reported for a degenerate axis");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");
`endif

endmodule
